// ===== rtl/core/keyframe_linear_interpolator_assert.svh =====
// Assertion macros for the checker of the keyframe interpolator.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define KLI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/kli_pkg.sv =====
package kli_pkg;

	// Field widths of one keyframe and of the interpolation datapath.
	localparam int TICK_W  = 31;
	localparam int POS_W   = 16;
	localparam int ALPHA_W = 8;
	localparam int QUO_W   = 16;
	localparam int PROD_W  = TICK_W + QUO_W;
	localparam int DIV_STEPS = QUO_W;

	// Item modes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Register byte address of key_count.
	localparam logic [2:0] ADDR_KEY_COUNT = 3'd0;

	// Channel being interpolated.
	localparam logic [1:0] FLD_X = 2'd0;
	localparam logic [1:0] FLD_Y = 2'd1;
	localparam logic [1:0] FLD_A = 2'd2;

	// One stored keyframe.
	typedef struct packed {
		logic        [TICK_W-1:0]  tick;
		logic signed [POS_W-1:0]   x;
		logic signed [POS_W-1:0]   y;
		logic        [ALPHA_W-1:0] alpha;
	} kli_entry_t;

	localparam int ENTRY_W = $bits(kli_entry_t);

	// Query sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_FIRST,
		ST_CHK_LAST,
		ST_MID,
		ST_CMP,
		ST_LD_LO,
		ST_LD_HI,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_ACC
	} kli_state_t;

endpackage

// ===== rtl/core/kli_ram.sv =====
module kli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one read port with registered data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/keyframe_linear_interpolator.sv =====
// Keyframe interpolator. A write item (mode 0) stores one keyframe and never
// raises busy. A query item (mode 1) raises busy unless key_count is zero,
// and ends with a one-cycle done strobe that carries in_range, pos_x, pos_y
// and opacity; the strobe cannot be held off, so the receiver must take it
// when it appears. With key_count zero the result comes the cycle after start.
// A tick before the first key is rejected in ST_CHK_FIRST, one at or after the
// last key in ST_CHK_LAST. Otherwise a binary search takes ST_MID and ST_CMP
// per step, at most ceil(log2(n-1)) steps for n keys. A tick on a key
// returns that key's values from ST_SETUP; one that falls between two keys runs
// ST_MUL, ST_DIV and ST_ACC for x, y and alpha in turn. The search and the key
// loads share the single RAM read port, and one multiply and a one-bit-per-cycle
// divider are reused for all three channels. A new start is taken in the same
// cycle as done.
module keyframe_linear_interpolator #(
	parameter int MAX_KEYS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               mode,
	input  logic [3:0]         key_index,
	input  logic [30:0]        tick,
	input  logic signed [15:0] key_x,
	input  logic signed [15:0] key_y,
	input  logic [7:0]         key_alpha,
	output logic               in_range,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic [7:0]         opacity
);

	import kli_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);

	// Control state.
	kli_state_t state_q, state_d;
	logic       done_q;
	logic [4:0] key_count_q;

	// Search and interpolation registers.
	logic [TICK_W-1:0]         tick_q;
	logic [AW-1:0]             last_q, lo_q, hi_q, mid_q;
	logic [TICK_W-1:0]         t0_q, t1_q, dt_q, den_q;
	logic signed [POS_W-1:0]   x0_q, y0_q, x1_q, y1_q;
	logic [ALPHA_W-1:0]        a0_q, a1_q;
	logic [1:0]                fld_q;
	logic                      sign_q;
	logic [TICK_W-1:0]         rem_q;
	logic [QUO_W-1:0]          dq_q;
	logic [$clog2(DIV_STEPS)-1:0] cnt_q;

	// Result registers.
	logic                      in_range_q;
	logic signed [POS_W-1:0]   pos_x_q, pos_y_q;
	logic [ALPHA_W-1:0]        opacity_q;

	// Combinational helpers.
	logic              accept, count_zero, cfg_wr;
	logic [AW-1:0]     last_d, mid, rd_addr, wr_addr;
	logic [AW:0]       mid_sum;
	logic              search_more, tick_lt_rd, clamp_lo, clamp_hi, div_last, fld_last;
	logic              finish, miss, ram_we;
	kli_entry_t        wr_entry, rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	logic signed [POS_W-1:0] v0s, v1s;
	logic signed [POS_W:0]   vdiff, delta, vsum;
	logic [POS_W:0]          vmag;
	logic [PROD_W-1:0]       prod;
	logic [TICK_W+1:0]       div_trial;
	logic                    div_take;

	// Keyframe store.
	assign wr_entry = '{tick: tick, x: key_x, y: key_y, alpha: key_alpha};
	assign wr_addr  = AW'(key_index);
	assign ram_we   = accept && (mode == MODE_WRITE) && (int'(key_index) < MAX_KEYS);
	assign rd_entry = rd_data;

	kli_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_KEYS)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_KEY_COUNT);
	assign prdata = (paddr == ADDR_KEY_COUNT) ? {27'd0, key_count_q} : 32'd0;

	// Handshake and index of the last valid key.
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign count_zero = (key_count_q == 5'd0);

	always_comb begin
		if (int'(key_count_q) >= MAX_KEYS) begin
			last_d = AW'(MAX_KEYS - 1);
		end else begin
			last_d = AW'(key_count_q - 5'd1);
		end
	end

	// Search midpoint and loop test.
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid         = mid_sum[AW:1];
	assign search_more = ({1'b0, lo_q} + (AW+1)'(1)) < {1'b0, hi_q};

	// Shared compares.
	assign tick_lt_rd = tick_q < rd_entry.tick;
	assign clamp_lo   = tick_q <= t0_q;
	assign clamp_hi   = tick_q >= t1_q;
	assign div_last   = (cnt_q == ($clog2(DIV_STEPS))'(DIV_STEPS - 1));
	assign fld_last   = (fld_q == FLD_A);

	// End values of the channel in work.
	always_comb begin
		case (fld_q)
			FLD_X: begin
				v0s = x0_q;
				v1s = x1_q;
			end
			FLD_Y: begin
				v0s = y0_q;
				v1s = y1_q;
			end
			FLD_A: begin
				v0s = {{(POS_W-ALPHA_W){1'b0}}, a0_q};
				v1s = {{(POS_W-ALPHA_W){1'b0}}, a1_q};
			end
			default: begin
				v0s = '0;
				v1s = '0;
			end
		endcase
	end

	// Magnitude of the value step times elapsed ticks.
	assign vdiff = {v1s[POS_W-1], v1s} - {v0s[POS_W-1], v0s};
	assign vmag  = vdiff[POS_W] ? (POS_W+1)'(-vdiff) : vdiff;
	assign prod  = PROD_W'(vmag[POS_W-1:0]) * PROD_W'(dt_q);

	// One restoring divide step.
	assign div_trial = {1'b0, rem_q, dq_q[QUO_W-1]} - {2'b00, den_q};
	assign div_take  = !div_trial[TICK_W+1];

	// Apply the signed quotient to the start value.
	assign delta = sign_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
	assign vsum  = {v0s[POS_W-1], v0s} + delta;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_QUERY) && !count_zero) begin
					state_d = ST_CHK_FIRST;
				end
			end
			ST_CHK_FIRST: state_d = tick_lt_rd ? ST_IDLE : ST_CHK_LAST;
			ST_CHK_LAST:  state_d = tick_lt_rd ? ST_MID : ST_IDLE;
			ST_MID:       state_d = search_more ? ST_CMP : ST_LD_LO;
			ST_CMP:       state_d = ST_MID;
			ST_LD_LO:     state_d = ST_LD_HI;
			ST_LD_HI:     state_d = ST_SETUP;
			ST_SETUP:     state_d = (clamp_lo || clamp_hi) ? ST_IDLE : ST_MUL;
			ST_MUL:       state_d = ST_DIV;
			ST_DIV:       state_d = div_last ? ST_ACC : ST_DIV;
			ST_ACC:       state_d = fld_last ? ST_IDLE : ST_MUL;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: read address and result events.
	always_comb begin
		rd_addr = '0;
		finish  = 1'b0;
		miss    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_QUERY) && count_zero) begin
					finish = 1'b1;
					miss   = 1'b1;
				end
			end
			ST_CHK_FIRST: begin
				rd_addr = last_q;
				finish  = tick_lt_rd;
				miss    = tick_lt_rd;
			end
			ST_CHK_LAST: begin
				finish = !tick_lt_rd;
				miss   = !tick_lt_rd;
			end
			ST_MID:   rd_addr = search_more ? mid : lo_q;
			ST_LD_LO: rd_addr = hi_q;
			ST_SETUP: finish  = clamp_lo || clamp_hi;
			ST_ACC:   finish  = fld_last;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			key_count_q <= 5'd0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (cfg_wr) begin
				key_count_q <= pwdata[4:0];
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tick_q <= tick;
					last_q <= last_d;
				end
			end
			ST_CHK_LAST: begin
				lo_q <= '0;
				hi_q <= last_q;
			end
			ST_MID: mid_q <= mid;
			ST_CMP: begin
				if (tick_lt_rd) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end
			ST_LD_LO: begin
				t0_q <= rd_entry.tick;
				x0_q <= rd_entry.x;
				y0_q <= rd_entry.y;
				a0_q <= rd_entry.alpha;
			end
			ST_LD_HI: begin
				t1_q <= rd_entry.tick;
				x1_q <= rd_entry.x;
				y1_q <= rd_entry.y;
				a1_q <= rd_entry.alpha;
			end
			ST_SETUP: begin
				if (clamp_lo) begin
					in_range_q <= 1'b1;
					pos_x_q    <= x0_q;
					pos_y_q    <= y0_q;
					opacity_q  <= a0_q;
				end else if (clamp_hi) begin
					in_range_q <= 1'b1;
					pos_x_q    <= x1_q;
					pos_y_q    <= y1_q;
					opacity_q  <= a1_q;
				end else begin
					dt_q  <= tick_q - t0_q;
					den_q <= t1_q - t0_q;
					fld_q <= FLD_X;
				end
			end
			ST_MUL: begin
				sign_q <= vdiff[POS_W];
				rem_q  <= prod[PROD_W-1:QUO_W];
				dq_q   <= prod[QUO_W-1:0];
				cnt_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= div_take ? div_trial[TICK_W-1:0] : {rem_q[TICK_W-2:0], dq_q[QUO_W-1]};
				dq_q  <= {dq_q[QUO_W-2:0], div_take};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_ACC: begin
				in_range_q <= 1'b1;
				fld_q      <= fld_q + 2'd1;
				case (fld_q)
					FLD_X:   pos_x_q   <= vsum[POS_W-1:0];
					FLD_Y:   pos_y_q   <= vsum[POS_W-1:0];
					FLD_A:   opacity_q <= vsum[ALPHA_W-1:0];
					default: ;
				endcase
			end
			default: ;
		endcase
		// A query outside the key span reports zeros.
		if (miss) begin
			in_range_q <= 1'b0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			opacity_q  <= '0;
		end
	end

	assign done     = done_q;
	assign in_range = in_range_q;
	assign pos_x    = pos_x_q;
	assign pos_y    = pos_y_q;
	assign opacity  = opacity_q;

endmodule

// ===== rtl/core/kli_chk.sv =====
`include "keyframe_linear_interpolator_assert.svh"

module kli_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               mode,
	input logic               in_range,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_y,
	input logic [7:0]         opacity
);

	// A result beat comes only once the block is free again.
	`KLI_ASSERT_SAME(a_done_not_busy, done, !busy, "result beat while busy")

	// Finishing a query always delivers its result.
	`KLI_ASSERT_SAME(a_fall_gives_done, $fell(busy), done, "query ended without result")

	// A keyframe write never produces a result beat.
	`KLI_ASSERT_NEXT(a_write_silent, start && !busy && !mode, !done, "result after write")

	// An accepted query either starts work or answers at once.
	`KLI_ASSERT_NEXT(a_query_acts, start && !busy && mode, busy || done, "query dropped")

	// Out-of-span results carry zeros.
	`KLI_ASSERT_SAME(a_miss_zero, done && !in_range,
		pos_x == 16'sd0 && pos_y == 16'sd0 && opacity == 8'd0, "nonzero miss result")

endmodule

bind keyframe_linear_interpolator kli_chk u_kli_chk (.*);
